### rtl/ccc_pkg.sv
// Shared types and constants for the column consensus caller.
package ccc_pkg;

  // Field widths
  localparam int COUNT_W   = 12;
  localparam int POS_W     = 16;
  localparam int THR_W     = 9;
  localparam int NUM_LANES = 6;

  // Ambiguity threshold after reset, about 0.6 in Q1.8
  localparam logic [THR_W-1:0] THR_RESET = 9'd154;

  // Counted ASCII characters
  localparam logic [7:0] SYM_A   = 8'h41;
  localparam logic [7:0] SYM_C   = 8'h43;
  localparam logic [7:0] SYM_G   = 8'h47;
  localparam logic [7:0] SYM_T   = 8'h54;
  localparam logic [7:0] SYM_GAP = 8'h5F;
  localparam logic [7:0] SYM_N   = 8'h4E;

  // Call codes; codes 0 to 5 double as counter lane numbers
  typedef enum logic [2:0] {
    CALL_A    = 3'd0,
    CALL_C    = 3'd1,
    CALL_G    = 3'd2,
    CALL_T    = 3'd3,
    CALL_GAP  = 3'd4,
    CALL_N    = 3'd5,
    CALL_NONE = 3'd6
  } call_t;

  // One input word
  typedef struct packed {
    logic [7:0] symbol;
    logic       column_end;
    logic       contig_start;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic [2:0]         call_code;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_c;
    logic [COUNT_W-1:0] count_g;
    logic [COUNT_W-1:0] count_t;
    logic [COUNT_W-1:0] count_gap;
    logic [COUNT_W-1:0] coverage;
    logic               ambiguous;
    logic               emitted;
    logic [POS_W-1:0]   position;
  } out_word_t;

  // Result handed from the tally to the output buffer
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

### rtl/ccc_tally.sv
// Column tally: per-column counters, running leader, and result formation.
module ccc_tally import ccc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             acc,
  input  in_word_t         in_word,
  output res_t             res
);

  localparam logic [COUNT_W-1:0] CNT_MAX = '1;
  localparam logic [POS_W-1:0]   POS_MAX = '1;
  localparam logic [POS_W-1:0]   POS_ONE = POS_W'(1);

  logic [THR_W-1:0]   thr_r;
  logic [COUNT_W-1:0] cnt_r [NUM_LANES];
  logic [COUNT_W-1:0] max_r;
  logic [COUNT_W-1:0] total_r;
  call_t              call_r;
  logic [POS_W-1:0]   pos_r;

  logic [NUM_LANES-1:0] hit;
  logic [COUNT_W-1:0]   inc      [NUM_LANES];
  logic [COUNT_W-1:0]   cnt_upd  [NUM_LANES];
  logic [COUNT_W-1:0]   max_upd;
  logic [COUNT_W-1:0]   total_upd;
  call_t                call_upd;
  logic [COUNT_W:0]     cov_sum;
  logic [COUNT_W+8:0]   lhs;
  logic [COUNT_W+8:0]   rhs;
  logic [POS_W-1:0]     pos_cur;
  logic [POS_W-1:0]     pos_nxt;
  logic                 emit;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + COUNT_W'(1);
  endfunction

  // Symbol decode to a one-hot lane
  always_comb begin
    hit = '0;
    unique case (in_word.symbol)
      SYM_A:   hit[CALL_A]   = 1'b1;
      SYM_C:   hit[CALL_C]   = 1'b1;
      SYM_G:   hit[CALL_G]   = 1'b1;
      SYM_T:   hit[CALL_T]   = 1'b1;
      SYM_GAP: hit[CALL_GAP] = 1'b1;
      SYM_N:   hit[CALL_N]   = 1'b1;
      default: hit = '0;
    endcase
  end

  // Counter bump and leader update; bases win ties, gap and N must exceed
  always_comb begin
    max_upd  = max_r;
    call_upd = call_r;
    for (int k = 0; k < NUM_LANES; k++) begin
      inc[k]     = sat_inc(cnt_r[k]);
      cnt_upd[k] = hit[k] ? inc[k] : cnt_r[k];
      if (hit[k]) begin
        if ((k <= int'(CALL_T)) ? (inc[k] >= max_r) : (inc[k] > max_r)) begin
          max_upd  = inc[k];
          call_upd = call_t'(3'(k));
        end
      end
    end
    total_upd = (|hit[CALL_GAP:CALL_A]) ? sat_inc(total_r) : total_r;
  end

  // Coverage, ambiguity test and position
  always_comb begin
    cov_sum = {1'b0, total_upd} + {1'b0, cnt_upd[CALL_N]};
    lhs     = {1'b0, max_upd, 8'b0};
    rhs     = (COUNT_W+9)'(thr_r) * (COUNT_W+9)'(total_upd);
    emit    = (call_upd != CALL_GAP);
    pos_cur = in_word.contig_start ? POS_ONE : pos_r;
    pos_nxt = (in_word.column_end && emit && pos_cur != POS_MAX) ?
              pos_cur + POS_W'(1) : pos_cur;

    res.valid          = acc && in_word.column_end;
    res.word.call_code = call_upd;
    res.word.count_a   = cnt_upd[CALL_A];
    res.word.count_c   = cnt_upd[CALL_C];
    res.word.count_g   = cnt_upd[CALL_G];
    res.word.count_t   = cnt_upd[CALL_T];
    res.word.count_gap = cnt_upd[CALL_GAP];
    res.word.coverage  = cov_sum[COUNT_W] ? CNT_MAX : cov_sum[COUNT_W-1:0];
    res.word.ambiguous = (total_upd != '0) && (lhs < rhs);
    res.word.emitted   = emit;
    res.word.position  = pos_cur;
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Column state; counters clear at column end, the call is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LANES; k++) cnt_r[k] <= '0;
      max_r   <= '0;
      total_r <= '0;
      call_r  <= CALL_NONE;
      pos_r   <= POS_ONE;
    end else if (acc) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        cnt_r[k] <= in_word.column_end ? '0 : cnt_upd[k];
      end
      max_r   <= in_word.column_end ? '0 : max_upd;
      total_r <= in_word.column_end ? '0 : total_upd;
      call_r  <= call_upd;
      pos_r   <= pos_nxt;
    end
  end

`ifndef SYNTHESIS
  // Column end leaves empty counters behind
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_word.column_end) |=> (total_r == '0 && max_r == '0))
    else $error("column state not cleared after column end");

  // Position counts from one and never wraps to zero
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != '0)
    else $error("position register reached zero");

  // A gap call never advances the position
  a_gap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.word.emitted) |=> (pos_r == $past(pos_cur)))
    else $error("position advanced on a gap call");
`endif

endmodule

### rtl/ccc_out_buf.sv
// Two-entry output buffer: result register plus skid register.
module ccc_out_buf import ccc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_t      push,
  input  logic      pop_ready,
  output logic      out_valid,
  output out_word_t out_word,
  output logic      full
);

  logic      main_vld_r;
  logic      skid_vld_r;
  out_word_t main_r;
  out_word_t skid_r;
  logic      pop;

  assign pop       = main_vld_r && pop_ready;
  assign out_valid = main_vld_r;
  assign out_word  = main_r;
  assign full      = skid_vld_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      main_vld_r <= skid_vld_r || push.valid;
      skid_vld_r <= 1'b0;
    end else if (push.valid) begin
      main_vld_r <= 1'b1;
      skid_vld_r <= main_vld_r;
    end
  end

  // Payload; the skid entry moves up when the main entry drains
  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= skid_vld_r ? skid_r : push.word;
    end else if (push.valid) begin
      if (main_vld_r) begin
        skid_r <= push.word;
      end else begin
        main_r <= push.word;
      end
    end
  end

`ifndef SYNTHESIS
  // Skid entry only holds data behind a full main entry
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid entry valid without main entry");

  // No push lands on a full buffer
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !skid_vld_r)
    else $error("push into full output buffer");

  // Draining with a waiting skid word keeps the output valid
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_vld_r) |=> (main_vld_r && main_r == $past(skid_r)))
    else $error("skid word lost on drain");
`endif

endmodule

### rtl/column_consensus_caller.sv
// A column's result is registered in the output buffer when its last word is taken.
// Throughput: one input word per cycle while in_ready is high; counter update, leader
// compare and 9 x 12 threshold multiply are combinational ahead of the result register.
// A two-entry output buffer absorbs stalls; in_ready drops only when both entries hold.
// Reset (rst_n low, synchronous): counts clear, call none, position 1, threshold 154.
module column_consensus_caller import ccc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word
);

  logic acc;
  logic buf_full;
  res_t res;

  // Input word is taken whenever the output buffer has a free entry
  assign in_ready = !buf_full;
  assign acc      = in_valid && in_ready;

  ccc_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_word   (in_word),
    .res       (res)
  );

  ccc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .pop_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .full      (buf_full)
  );

endmodule
